@@ hw/rtl/ihf_pkg.sv @@
// shared types, register indexes and widths of the hole fill block
package ihf_pkg;

  localparam int PIX_W     = 24;
  localparam int PASS_W    = 8;
  localparam int DIM_W     = 9;
  localparam int CRD_W     = 9;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 24;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam logic [CFG_IDX_W-1:0] CFG_UNDEF_COLOR = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PASSES  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_WIDTH   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_HEIGHT  = CFG_IDX_W'(3);

  localparam logic [PIX_W-1:0]  RST_UNDEF_COLOR = '0;
  localparam logic [PASS_W-1:0] RST_MAX_PASSES  = PASS_W'(5);
  localparam logic [DIM_W-1:0]  RST_IMG_WIDTH   = DIM_W'(256);
  localparam logic [DIM_W-1:0]  RST_IMG_HEIGHT  = DIM_W'(256);

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_RUN   = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_PASS,
    ST_CENTER,
    ST_SCAN,
    ST_PASS_END,
    ST_FINISH
  } state_t;

endpackage

@@ hw/rtl/ihf_cmd_if.sv @@
// command channel: write, run and read items
interface ihf_cmd_if;
  import ihf_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       op;
  logic [7:0]       col;
  logic [7:0]       row;
  logic [PIX_W-1:0] write_color;

  modport source (output valid, op, col, row, write_color, input ready);
  modport sink   (input valid, op, col, row, write_color, output ready);
endinterface

@@ hw/rtl/ihf_rsp_if.sv @@
// result channel: pixel colour or pass count
interface ihf_rsp_if;
  import ihf_pkg::*;

  logic              valid;
  logic              ready;
  logic [PIX_W-1:0]  read_color;
  logic [PASS_W-1:0] passes_run;

  modport source (output valid, read_color, passes_run, input ready);
  modport sink   (input valid, read_color, passes_run, output ready);
endinterface

@@ hw/rtl/ihf_cfg_if.sv @@
// configuration write channel
interface ihf_cfg_if;
  import ihf_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/ihf_ram.sv @@
// generic simple dual port ram with registered read
module ihf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/image_hole_fill.sv @@
// hole filling over a stored image: pixel store, pass sequencer, result register
// write item: stored on accept, no result. read item: result once the slot is free.
// run item: per pass each pixel is checked, and each hole is scanned over its clipped
//   3x3 neighbourhood (one store read per cycle) until a defined neighbour fills it;
//   result once the slot is free after the last pass; one item at a time
// reset: configuration registers to their defaults, sequencer idle, no result pending; the pixel store is not cleared
module image_hole_fill #(
  parameter int MAX_WIDTH  = ihf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ihf_pkg::DEF_MAX_HEIGHT
) (
  input  logic      clk,
  input  logic      rst,
  ihf_cmd_if.sink   cmd,
  ihf_rsp_if.source rsp,
  ihf_cfg_if.sink   cfg
);
  import ihf_pkg::*;

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = $clog2(DEPTH);
  localparam int W_CLIP = (MAX_WIDTH > 511) ? 511 : MAX_WIDTH;
  localparam int H_CLIP = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;
  localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_WIDTH);

  // configuration
  logic [PIX_W-1:0]  undefined_color;
  logic [PASS_W-1:0] max_passes;
  logic [DIM_W-1:0]  image_width;
  logic [DIM_W-1:0]  image_height;

  // sequencer and datapath
  state_t            state, state_next;
  logic [CRD_W-1:0]  x, y, sx, sy;
  logic [PASS_W-1:0] passes;
  logic              changed;
  logic              rd_in_store;

  logic              rsp_valid;
  logic [PIX_W-1:0]  rsp_color;
  logic [PASS_W-1:0] rsp_passes;

  // store ports
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [PIX_W-1:0] ram_wdata, ram_rdata;
  logic [CRD_W-1:0] rd_y, rd_x;

  logic [DIM_W-1:0] w, h;
  logic [CRD_W-1:0] x_lo, x_hi, y_lo, y_hi, nx, ny;
  logic             x_end, y_end, pix_last, scan_last, hit, slot_free, accept, in_store;
  op_t              cmd_op;

  function automatic logic [AW-1:0] addr_of(input logic [CRD_W-1:0] yy,
                                            input logic [CRD_W-1:0] xx);
    addr_of = AW'(yy) * ROW_STRIDE + AW'(xx);
  endfunction

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      undefined_color <= RST_UNDEF_COLOR;
      max_passes      <= RST_MAX_PASSES;
      image_width     <= RST_IMG_WIDTH;
      image_height    <= RST_IMG_HEIGHT;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_UNDEF_COLOR: undefined_color <= cfg.data[PIX_W-1:0];
        CFG_MAX_PASSES:  max_passes      <= cfg.data[PASS_W-1:0];
        CFG_IMG_WIDTH:   image_width     <= cfg.data[DIM_W-1:0];
        CFG_IMG_HEIGHT:  image_height    <= cfg.data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // dimensions clipped to the store
  assign w = (image_width > DIM_W'(W_CLIP)) ? DIM_W'(W_CLIP) : image_width;
  assign h = (image_height > DIM_W'(H_CLIP)) ? DIM_W'(H_CLIP) : image_height;

  // neighbourhood bounds, inclusive
  assign x_lo = (x == '0) ? x : x - CRD_W'(1);
  assign y_lo = (y == '0) ? y : y - CRD_W'(1);
  assign x_hi = (({1'b0, x} + (CRD_W+1)'(1)) < {1'b0, w}) ? x + CRD_W'(1) : x;
  assign y_hi = (({1'b0, y} + (CRD_W+1)'(1)) < {1'b0, h}) ? y + CRD_W'(1) : y;

  assign x_end    = ({1'b0, x} + (CRD_W+1)'(1)) == {1'b0, w};
  assign y_end    = ({1'b0, y} + (CRD_W+1)'(1)) == {1'b0, h};
  assign pix_last = x_end && y_end;
  assign nx       = x_end ? '0 : x + CRD_W'(1);
  assign ny       = x_end ? y + CRD_W'(1) : y;

  assign scan_last = (sx == x_hi) && (sy == y_hi);
  assign hit       = ram_rdata != undefined_color;
  assign slot_free = !rsp_valid || rsp.ready;
  assign accept    = cmd.valid && cmd.ready;
  assign in_store  = (int'(cmd.col) < MAX_WIDTH) && (int'(cmd.row) < MAX_HEIGHT);
  assign cmd_op    = op_t'(cmd.op);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_op)
            OP_RUN:  state_next = ST_PASS;
            OP_READ: state_next = ST_READ;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_READ: begin
        if (slot_free) state_next = ST_IDLE;
      end
      ST_PASS: begin
        priority if (passes == max_passes)    state_next = ST_FINISH;
        else if (w == '0 || h == '0)          state_next = ST_PASS_END;
        else                                  state_next = ST_CENTER;
      end
      ST_CENTER: begin
        if (!hit)          state_next = ST_SCAN;
        else if (pix_last) state_next = ST_PASS_END;
      end
      ST_SCAN: begin
        if (hit || scan_last) state_next = pix_last ? ST_PASS_END : ST_CENTER;
      end
      ST_PASS_END: state_next = changed ? ST_PASS : ST_FINISH;
      ST_FINISH: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // store access per state
  always_comb begin
    cmd.ready = state == ST_IDLE;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    rd_y      = y;
    rd_x      = x;
    ram_waddr = addr_of(y, x);
    ram_wdata = ram_rdata;
    unique case (state)
      ST_IDLE: begin
        rd_y      = {1'b0, cmd.row};
        rd_x      = {1'b0, cmd.col};
        ram_re    = accept && cmd_op == OP_READ && in_store;
        ram_we    = accept && cmd_op == OP_WRITE && in_store;
        ram_waddr = addr_of({1'b0, cmd.row}, {1'b0, cmd.col});
        ram_wdata = cmd.write_color;
      end
      ST_PASS: begin
        ram_re = 1'b1;
        rd_y   = '0;
        rd_x   = '0;
      end
      ST_CENTER: begin
        if (!hit) begin
          ram_re = 1'b1;
          rd_y   = y_lo;
          rd_x   = x_lo;
        end else begin
          ram_re = !pix_last;
          rd_y   = ny;
          rd_x   = nx;
        end
      end
      ST_SCAN: begin
        ram_we = hit;
        if (hit || scan_last) begin
          ram_re = !pix_last;
          rd_y   = ny;
          rd_x   = nx;
        end else begin
          ram_re = 1'b1;
          rd_y   = (sx == x_hi) ? sy + CRD_W'(1) : sy;
          rd_x   = (sx == x_hi) ? x_lo : sx + CRD_W'(1);
        end
      end
      default: ;
    endcase
    ram_raddr = addr_of(rd_y, rd_x);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      passes  <= '0;
      changed <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            passes      <= '0;
            rd_in_store <= in_store;
          end
        end
        ST_PASS: begin
          // the count only grows when another pass really starts
          if (passes != max_passes) passes <= passes + PASS_W'(1);
          changed <= 1'b0;
          x       <= '0;
          y       <= '0;
        end
        ST_CENTER: begin
          if (hit) begin
            x <= nx;
            y <= ny;
          end else begin
            sx <= x_lo;
            sy <= y_lo;
          end
        end
        ST_SCAN: begin
          if (hit) changed <= 1'b1;
          if (hit || scan_last) begin
            x <= nx;
            y <= ny;
          end else if (sx == x_hi) begin
            sx <= x_lo;
            sy <= sy + CRD_W'(1);
          end else begin
            sx <= sx + CRD_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // result register, freed as the sink takes the item
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      if (state == ST_READ && slot_free) begin
        rsp_valid  <= 1'b1;
        rsp_color  <= rd_in_store ? ram_rdata : '0;
        rsp_passes <= '0;
      end else if (state == ST_FINISH && slot_free) begin
        rsp_valid  <= 1'b1;
        rsp_color  <= '0;
        rsp_passes <= passes;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.read_color = rsp_color;
  assign rsp.passes_run = rsp_passes;

  ihf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_passes == '0 || rsp_color == '0))
    else $error("result carries both a colour and a pass count");

  a_pass_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CENTER || state == ST_SCAN || state == ST_PASS_END) |->
      (passes <= max_passes && passes != '0))
    else $error("pass count outside its bound during a run");

  a_scan_window: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |->
      (sx >= x_lo && sx <= x_hi && sy >= y_lo && sy <= y_hi))
    else $error("scan position left the neighbourhood");

  a_run_write: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state != ST_IDLE) |=> (state == ST_CENTER || state == ST_PASS_END))
    else $error("fill write did not end the neighbourhood scan");

endmodule
